>>> sv/cpt_pkg.sv
package cpt_pkg;

  // Default widths of the coordinate and angle fields.
  localparam int unsigned CPT_COORD_WIDTH = 32;
  localparam int unsigned CPT_ANGLE_BITS  = 16;

  // Bits of the scaled transverse root; the arctangent operands live in this range.
  localparam int unsigned CPT_ROOT_BITS = 63;

  // Arctangent datapath geometry.
  localparam int unsigned CPT_NORM_STAGES   = 6;
  localparam int unsigned CPT_CORDIC_STAGES = 30;
  localparam int unsigned CPT_ANG_W         = 31;
  localparam int unsigned CPT_Z_W           = 34;
  localparam int unsigned CPT_TAB_W         = 30;

  // Signs and validity of one vector, carried alongside the datapath.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic phi_ok;
    logic theta_ok;
  } cpt_flags_t;

  localparam int unsigned CPT_FLAGS_W = $bits(cpt_flags_t);

  // Rotation angle atan(2^-idx) in units of one turn / 2^32.
  function automatic logic [CPT_TAB_W-1:0] cpt_atan_step(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051D;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      20:      v = 32'h0000028B;
      21:      v = 32'h00000145;
      22:      v = 32'h000000A2;
      23:      v = 32'h00000051;
      24:      v = 32'h00000028;
      25:      v = 32'h00000014;
      26:      v = 32'h0000000A;
      27:      v = 32'h00000005;
      28:      v = 32'h00000002;
      29:      v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v[CPT_TAB_W-1:0];
  endfunction

endpackage

>>> sv/cpt_if.sv
// Input channel: one Cartesian vector per item.
interface cpt_in_if #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CPT_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] px;
  logic signed [COORD_WIDTH-1:0] py;
  logic signed [COORD_WIDTH-1:0] pz;

  modport source (output valid, px, py, pz, input ready);
  modport sink   (input valid, px, py, pz, output ready);
endinterface

// Output channel: pt, phi and theta with their valid flags per item.
interface cpt_out_if #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CPT_COORD_WIDTH,
  parameter int unsigned ANGLE_BITS  = cpt_pkg::CPT_ANGLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] pt;
  logic [ANGLE_BITS:0]    phi;
  logic                   phi_valid;
  logic [ANGLE_BITS-1:0]  theta;
  logic                   theta_valid;

  modport source (output valid, pt, phi, phi_valid, theta, theta_valid, input ready);
  modport sink   (input valid, pt, phi, phi_valid, theta, theta_valid, output ready);
endinterface

>>> sv/cpt_front.sv
// Magnitudes, squares and the transverse sum of squares, three stages.
module cpt_front #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CPT_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  logic signed [COORD_WIDTH-1:0] pz_i,
  output logic                          valid_o,
  output logic [2*COORD_WIDTH-1:0]      s_o,
  output logic [COORD_WIDTH-1:0]        mag_o [3],
  output cpt_pkg::cpt_flags_t           flags_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned SW = 2 * COORD_WIDTH;

  logic [W-1:0]        raw   [3];
  logic [W-1:0]        a_mag_q [3];
  logic [2:0]          a_neg_q;
  logic                a_vld_q;
  logic [SW-1:0]       b_sq_q [2];
  logic [W-1:0]        b_mag_q [3];
  cpt_pkg::cpt_flags_t b_flags_q;
  logic                b_vld_q;
  logic [SW-1:0]       c_s_q;
  logic [W-1:0]        c_mag_q [3];
  cpt_pkg::cpt_flags_t c_flags_q;
  logic                c_vld_q;

  assign raw[0] = px_i;
  assign raw[1] = py_i;
  assign raw[2] = pz_i;

  // Stage A: absolute values; the most negative code maps to its unsigned magnitude.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        a_mag_q[c] <= raw[c][W-1] ? (~raw[c] + W'(1)) : raw[c];
        a_neg_q[c] <= raw[c][W-1];
      end
    end
  end

  // Stage B: squares of the transverse components and the zero checks.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_sq_q[0]          <= SW'(a_mag_q[0]) * SW'(a_mag_q[0]);
      b_sq_q[1]          <= SW'(a_mag_q[1]) * SW'(a_mag_q[1]);
      b_mag_q            <= a_mag_q;
      b_flags_q.neg_x    <= a_neg_q[0];
      b_flags_q.neg_y    <= a_neg_q[1];
      b_flags_q.neg_z    <= a_neg_q[2];
      b_flags_q.phi_ok   <= (a_mag_q[0] != '0) || (a_mag_q[1] != '0);
      b_flags_q.theta_ok <= (a_mag_q[0] != '0) || (a_mag_q[1] != '0) || (a_mag_q[2] != '0);
    end
  end

  // Stage C: sum of squares; it stays below 2^(2W-1) + 1 and fits 2W bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_s_q     <= b_sq_q[0] + b_sq_q[1];
      c_mag_q   <= b_mag_q;
      c_flags_q <= b_flags_q;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  assign valid_o = c_vld_q;
  assign s_o     = c_s_q;
  assign mag_o   = c_mag_q;
  assign flags_o = c_flags_q;

endmodule

>>> sv/cpt_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
// After COORD_WIDTH stages the root is floor(sqrt(s)) and pt is rounded from it;
// the remaining stages extend the root by zero digit pairs to floor(sqrt(s) * 2^k).
module cpt_sqrt #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CPT_COORD_WIDTH,
  parameter int unsigned SIDE_W      = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [2*COORD_WIDTH-1:0]    s_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [COORD_WIDTH-1:0]      pt_o,
  output logic [cpt_pkg::CPT_ROOT_BITS-1:0] root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned SW    = 2 * COORD_WIDTH;
  localparam int unsigned R     = cpt_pkg::CPT_ROOT_BITS;
  localparam int unsigned REM_W = R + 3;

  logic [R-1:0]      root_q [1:R];
  logic [REM_W-1:0]  rem_q  [1:R];
  logic [SW-1:0]     s_q    [1:W-1];
  logic [W-1:0]      pt_q   [W+1:R];
  logic [SIDE_W-1:0] side_q [1:R];
  logic              vld_q  [1:R];

  for (genvar i = 0; i < R; i++) begin : g_step
    logic [R-1:0]      root_p;
    logic [REM_W-1:0]  rem_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [1:0]        pair;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign root_p = '0;
      assign rem_p  = '0;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign root_p = root_q[i];
      assign rem_p  = rem_q[i];
      assign side_p = side_q[i];
      assign vld_p  = vld_q[i];
    end

    // Radicand digit pairs come from s first, then zeros.
    if (i == 0) begin : g_pair_in
      assign pair = s_i[SW-1 -: 2];
    end else if (i < W) begin : g_pair_s
      assign pair = s_q[i][SW-1-2*i -: 2];
    end else begin : g_pair_zero
      assign pair = 2'b00;
    end

    assign cur   = {rem_p[REM_W-3:0], pair};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= ge ? (cur - trial) : cur;
        root_q[i+1] <= {root_p[R-2:0], ge};
        side_q[i+1] <= side_p;
      end
    end

    // Carry the radicand while its digits are still needed.
    if (i + 1 < W) begin : g_s_carry
      if (i == 0) begin : g_s_first
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            s_q[1] <= s_i;
          end
        end
      end else begin : g_s_next
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            s_q[i+1] <= s_q[i];
          end
        end
      end
    end

    // Round pt to nearest: increment when the remainder exceeds the floor root.
    if (i == W) begin : g_pt_round
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pt_q[i+1] <= root_p[W-1:0] + W'(rem_p > REM_W'(root_p));
        end
      end
    end else if (i > W) begin : g_pt_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pt_q[i+1] <= pt_q[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_p;
      end
    end
  end

  assign valid_o = vld_q[R];
  assign pt_o    = pt_q[R];
  assign root_o  = root_q[R];
  assign side_o  = side_q[R];

endmodule

>>> sv/cpt_atan.sv
// Two-lane first-quadrant arctangent atan2(v, u) in units of one turn / 2^32.
// Each lane normalizes its operand pair in six shift stages, then runs a
// 30-stage CORDIC vectoring pipeline and a final clamp stage.
module cpt_atan #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [cpt_pkg::CPT_ROOT_BITS-1:0]   u_i [2],
  input  logic [cpt_pkg::CPT_ROOT_BITS-1:0]   v_i [2],
  input  logic [SIDE_W-1:0]                   side_i,
  output logic                                valid_o,
  output logic [cpt_pkg::CPT_ANG_W-1:0]       ang_o [2],
  output logic [SIDE_W-1:0]                   side_o
);

  localparam int unsigned L    = 2;
  localparam int unsigned NORM = cpt_pkg::CPT_NORM_STAGES;
  localparam int unsigned CS   = cpt_pkg::CPT_CORDIC_STAGES;
  localparam int unsigned AW   = cpt_pkg::CPT_ANG_W;
  localparam int unsigned ZW   = cpt_pkg::CPT_Z_W;
  localparam logic signed [ZW-1:0] Z_MAX = ZW'(1) <<< (AW - 1);

  logic [63:0]              nu_q   [0:NORM][L];
  logic [63:0]              nv_q   [0:NORM][L];
  logic                     nuz_q  [0:NORM][L];
  logic                     nvz_q  [0:NORM][L];
  logic [SIDE_W-1:0]        nside_q [0:NORM];
  logic                     nvld_q  [0:NORM];

  logic signed [63:0]       cx_q   [1:CS][L];
  logic signed [63:0]       cy_q   [1:CS][L];
  logic signed [ZW-1:0]     cz_q   [1:CS][L];
  logic                     cuz_q  [1:CS][L];
  logic                     cvz_q  [1:CS][L];
  logic [SIDE_W-1:0]        cside_q [1:CS];
  logic                     cvld_q  [1:CS];

  logic [AW-1:0]            ang_q  [L];
  logic [SIDE_W-1:0]        side_q;
  logic                     vld_q;

  for (genvar l = 0; l < L; l++) begin : g_lane
    // Entry: widen to 64 bits and note the axis cases.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nu_q[0][l]  <= {1'b0, u_i[l]};
        nv_q[0][l]  <= {1'b0, v_i[l]};
        nuz_q[0][l] <= (u_i[l] == '0);
        nvz_q[0][l] <= (v_i[l] == '0);
      end
    end

    // Normalize: shift left until the larger operand has its top bit set.
    for (genvar j = 0; j < NORM; j++) begin : g_norm
      localparam int unsigned NS = 32 >> j;
      logic [63:0] m;
      assign m = nu_q[j][l] | nv_q[j][l];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (m[63 -: NS] == '0) begin
            nu_q[j+1][l] <= nu_q[j][l] << NS;
            nv_q[j+1][l] <= nv_q[j][l] << NS;
          end else begin
            nu_q[j+1][l] <= nu_q[j][l];
            nv_q[j+1][l] <= nv_q[j][l];
          end
          nuz_q[j+1][l] <= nuz_q[j][l];
          nvz_q[j+1][l] <= nvz_q[j][l];
        end
      end
    end

    // CORDIC vectoring: drive y toward zero and accumulate the angle.
    for (genvar i = 0; i < CS; i++) begin : g_rot
      logic signed [63:0]   xp;
      logic signed [63:0]   yp;
      logic signed [ZW-1:0] zp;
      logic                 uzp;
      logic                 vzp;
      logic signed [63:0]   xs;
      logic signed [63:0]   ys;
      logic signed [ZW-1:0] tab;

      if (i == 0) begin : g_first
        // Operands scaled so the larger one lies in [2^59, 2^60).
        assign xp  = signed'({4'b0000, nu_q[NORM][l][63:4]});
        assign yp  = signed'({4'b0000, nv_q[NORM][l][63:4]});
        assign zp  = '0;
        assign uzp = nuz_q[NORM][l];
        assign vzp = nvz_q[NORM][l];
      end else begin : g_next
        assign xp  = cx_q[i][l];
        assign yp  = cy_q[i][l];
        assign zp  = cz_q[i][l];
        assign uzp = cuz_q[i][l];
        assign vzp = cvz_q[i][l];
      end

      assign xs  = xp >>> i;
      assign ys  = yp >>> i;
      assign tab = signed'(ZW'(cpt_pkg::cpt_atan_step(i)));

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!yp[63]) begin
            cx_q[i+1][l] <= xp + ys;
            cy_q[i+1][l] <= yp - xs;
            cz_q[i+1][l] <= zp + tab;
          end else begin
            cx_q[i+1][l] <= xp - ys;
            cy_q[i+1][l] <= yp + xs;
            cz_q[i+1][l] <= zp - tab;
          end
          cuz_q[i+1][l] <= uzp;
          cvz_q[i+1][l] <= vzp;
        end
      end
    end

    // Clamp to a quarter turn; the axis cases override the rotation result.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cvz_q[CS][l]) begin
          ang_q[l] <= '0;
        end else if (cuz_q[CS][l]) begin
          ang_q[l] <= AW'(Z_MAX);
        end else if (cz_q[CS][l][ZW-1]) begin
          ang_q[l] <= '0;
        end else if (cz_q[CS][l] > Z_MAX) begin
          ang_q[l] <= AW'(Z_MAX);
        end else begin
          ang_q[l] <= cz_q[CS][l][AW-1:0];
        end
      end
    end
  end

  // Side data follows the lanes stage by stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nside_q[0] <= side_i;
      for (int j = 0; j < NORM; j++) begin
        nside_q[j+1] <= nside_q[j];
      end
      cside_q[1] <= nside_q[NORM];
      for (int i = 1; i < CS; i++) begin
        cside_q[i+1] <= cside_q[i];
      end
      side_q <= cside_q[CS];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= NORM; j++) begin
        nvld_q[j] <= 1'b0;
      end
      for (int i = 1; i <= CS; i++) begin
        cvld_q[i] <= 1'b0;
      end
      vld_q <= 1'b0;
    end else if (en_i) begin
      nvld_q[0] <= valid_i;
      for (int j = 0; j < NORM; j++) begin
        nvld_q[j+1] <= nvld_q[j];
      end
      cvld_q[1] <= nvld_q[NORM];
      for (int i = 1; i < CS; i++) begin
        cvld_q[i+1] <= cvld_q[i];
      end
      vld_q <= cvld_q[CS];
    end
  end

  assign valid_o = vld_q;
  assign ang_o   = ang_q;
  assign side_o  = side_q;

endmodule

>>> sv/cartesian_to_pt_phi_theta.sv
// Throughput: one item per cycle while the receiver does not stall a full output register;
// the front end (3), the square root (63 stages), the arctangent lanes (38) and
// the output register (1) are all fully pipelined.
// The pipeline advances whenever its last stage is empty or the output register can load.
// Reset (rst_ni low, asynchronous) clears all valid bits; no item is in flight after it.
module cartesian_to_pt_phi_theta #(
  parameter int unsigned COORD_WIDTH = cpt_pkg::CPT_COORD_WIDTH,
  parameter int unsigned ANGLE_BITS  = cpt_pkg::CPT_ANGLE_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cpt_in_if.sink   in_i,
  cpt_out_if.source out_o
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned R      = cpt_pkg::CPT_ROOT_BITS;
  localparam int unsigned K      = R - COORD_WIDTH;
  localparam int unsigned AW     = cpt_pkg::CPT_ANG_W;
  localparam int unsigned FW     = cpt_pkg::CPT_FLAGS_W;
  localparam int unsigned SQ_SIDE = 3 * COORD_WIDTH + FW;
  localparam int unsigned AT_SIDE = COORD_WIDTH + FW;
  localparam logic [32:0] TURN_HALF = 33'h0_8000_0000;
  localparam logic [32:0] TURN_FULL = 33'h1_0000_0000;
  localparam logic [32:0] ROUND_HALF = 33'(1) << (31 - ANGLE_BITS);

  logic                 en;
  logic                 fr_vld;
  logic [2*W-1:0]       fr_s;
  logic [W-1:0]         fr_mag [3];
  cpt_pkg::cpt_flags_t  fr_flags;
  logic                 sq_vld;
  logic [W-1:0]         sq_pt;
  logic [R-1:0]         sq_root;
  logic [SQ_SIDE-1:0]   sq_side;
  logic [W-1:0]         sq_mag [3];
  cpt_pkg::cpt_flags_t  sq_flags;
  logic [R-1:0]         at_u [2];
  logic [R-1:0]         at_v [2];
  logic                 at_vld;
  logic [AW-1:0]        at_ang [2];
  logic [AT_SIDE-1:0]   at_side;
  logic [W-1:0]         at_pt;
  cpt_pkg::cpt_flags_t  at_flags;

  logic [32:0]           phi_t;
  logic [32:0]           phi_sum;
  logic [32:0]           th_t;
  logic [32:0]           th_sum;

  logic                  out_vld_q;
  logic [W-1:0]          out_pt_q;
  logic [ANGLE_BITS:0]   out_phi_q;
  logic                  out_phi_ok_q;
  logic [ANGLE_BITS-1:0] out_th_q;
  logic                  out_th_ok_q;

  // The whole pipeline moves unless a finished item would be dropped.
  assign en        = !at_vld || !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  cpt_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .px_i    (in_i.px),
    .py_i    (in_i.py),
    .pz_i    (in_i.pz),
    .valid_o (fr_vld),
    .s_o     (fr_s),
    .mag_o   (fr_mag),
    .flags_o (fr_flags)
  );

  cpt_sqrt #(
    .COORD_WIDTH (COORD_WIDTH),
    .SIDE_W      (SQ_SIDE)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .s_i     (fr_s),
    .side_i  ({fr_mag[0], fr_mag[1], fr_mag[2], fr_flags}),
    .valid_o (sq_vld),
    .pt_o    (sq_pt),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign {sq_mag[0], sq_mag[1], sq_mag[2], sq_flags} = sq_side;

  // Lane 0 gives the azimuth from (|px|, |py|); lane 1 the polar angle from (|pz|, pt).
  assign at_u[0] = R'(sq_mag[0]);
  assign at_v[0] = R'(sq_mag[1]);
  assign at_u[1] = R'(sq_mag[2]) << K;
  assign at_v[1] = sq_root;

  cpt_atan #(
    .SIDE_W (AT_SIDE)
  ) u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .u_i     (at_u),
    .v_i     (at_v),
    .side_i  ({sq_pt, sq_flags}),
    .valid_o (at_vld),
    .ang_o   (at_ang),
    .side_o  (at_side)
  );

  assign {at_pt, at_flags} = at_side;

  // Unfold the azimuth into the full turn by the signs of px and py.
  always_comb begin
    case ({at_flags.neg_x, at_flags.neg_y})
      2'b00:   phi_t = {2'b00, at_ang[0]};
      2'b10:   phi_t = TURN_HALF - {2'b00, at_ang[0]};
      2'b11:   phi_t = TURN_HALF + {2'b00, at_ang[0]};
      default: phi_t = TURN_FULL - {2'b00, at_ang[0]};
    endcase
  end

  // The polar angle mirrors about a quarter turn for negative pz.
  assign th_t    = at_flags.neg_z ? (TURN_HALF - {2'b00, at_ang[1]}) : {2'b00, at_ang[1]};
  assign phi_sum = phi_t + ROUND_HALF;
  assign th_sum  = th_t + ROUND_HALF;

  // Output register: loads when empty or when its item is taken.
  always_ff @(posedge clk_i) begin
    if ((!out_vld_q || out_o.ready) && at_vld) begin
      out_pt_q     <= at_pt;
      out_phi_q    <= at_flags.phi_ok ? phi_sum[32 -: ANGLE_BITS+1] : '0;
      out_phi_ok_q <= at_flags.phi_ok;
      out_th_q     <= at_flags.theta_ok ? th_sum[31 -: ANGLE_BITS] : '0;
      out_th_ok_q  <= at_flags.theta_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= at_vld;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.pt          = out_pt_q;
  assign out_o.phi         = out_phi_q;
  assign out_o.phi_valid   = out_phi_ok_q;
  assign out_o.theta       = out_th_q;
  assign out_o.theta_valid = out_th_ok_q;

  // A defined azimuth needs nonzero transverse momentum, hence a defined polar angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.phi_valid || out_o.theta_valid))
    else $error("phi valid without theta valid");

  // An undefined azimuth is reported as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.phi_valid) |-> (out_o.phi == '0))
    else $error("invalid phi is not zero");

  // The polar angle never exceeds half a turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.theta <= (ANGLE_BITS)'(1) << (ANGLE_BITS - 1)))
    else $error("theta above half a turn");

  // A zero vector gives zero pt and zero theta.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.theta_valid) |-> (out_o.theta == '0 && out_o.pt == '0))
    else $error("zero vector with nonzero pt or theta");

endmodule

>>> dv/tb_cartesian_to_pt_phi_theta.sv
module tb_cartesian_to_pt_phi_theta;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = cpt_pkg::CPT_COORD_WIDTH;
  localparam int unsigned AB = cpt_pkg::CPT_ANGLE_BITS;
  localparam int unsigned LATENCY = 105;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned N_RANDOM = 1625;
  localparam int unsigned HOLD_CYCLES = 1500;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
  } vec_t;

  typedef struct packed {
    logic [CW-1:0] pt;
    logic [AB:0]   phi;
    logic          phi_valid;
    logic [AB-1:0] theta;
    logic          theta_valid;
  } polar_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpt_in_if  #(.COORD_WIDTH(CW)) in_if ();
  cpt_out_if #(.COORD_WIDTH(CW), .ANGLE_BITS(AB)) out_if ();

  cartesian_to_pt_phi_theta #(.COORD_WIDTH(CW), .ANGLE_BITS(AB)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  vec_t   pending_vecs[$];
  polar_t expected_polar[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned idle_cycles = 0;
  bit hold_req = 1'b0;
  bit in_acc = 1'b0;
  bit out_acc = 1'b0;

  // Arctangent table in units of one turn / 2^32.
  function automatic logic [63:0] rot_step(int i);
    logic [31:0] t[30] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};
    return {32'd0, t[i]};
  endfunction

  // Floor square root of a 128-bit value, one result bit per pass.
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] b;
    logic [127:0] t;
    r = '0;
    b = 128'd1 << 126;
    while (b != 0 && n < b) b = b >> 2;
    while (b != 0) begin
      t = r + b;
      if (n >= t) begin
        n = n - t;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  // First-quadrant arctangent by shift-and-add rotation, turn / 2^32.
  function automatic logic [63:0] quadrant_angle(logic [63:0] u, logic [63:0] v);
    logic [63:0] m;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    if (v == 0) return 64'd0;
    if (u == 0) return 64'd1 << 30;
    m = u | v;
    while ((m >> 60) != 0) begin
      u = u >> 1; v = v >> 1; m = m >> 1;
    end
    while ((m >> 59) == 0) begin
      u = u << 1; v = v << 1; m = m << 1;
    end
    x = u;
    y = v;
    z = 0;
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + signed'(rot_step(i));
      end else begin
        x = x - ys; y = y + xs; z = z - signed'(rot_step(i));
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
    return z;
  endfunction

  function automatic logic [63:0] round_angle(logic [63:0] turn);
    return (turn + (64'd1 << (31 - AB))) >> (32 - AB);
  endfunction

  // Expected pt, azimuth and polar angle of one vector.
  function automatic polar_t to_polar(vec_t v);
    logic [63:0]  mx;
    logic [63:0]  my;
    logic [63:0]  mz;
    logic [127:0] s;
    logic [127:0] rem;
    logic [63:0]  pt;
    logic [63:0]  a;
    logic [63:0]  t;
    logic [63:0]  ptx;
    polar_t r;
    mx = v.px[CW-1] ? 64'(-signed'({1'b1, v.px})) : 64'(v.px);
    my = v.py[CW-1] ? 64'(-signed'({1'b1, v.py})) : 64'(v.py);
    mz = v.pz[CW-1] ? 64'(-signed'({1'b1, v.pz})) : 64'(v.pz);
    s = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
    pt = floor_root(s);
    rem = s - 128'(pt) * 128'(pt);
    if (rem > 128'(pt)) pt = pt + 1;
    r = '0;
    r.pt = pt[CW-1:0];
    r.phi_valid = (s != 0);
    r.theta_valid = r.phi_valid || (mz != 0);
    if (r.phi_valid) begin
      a = quadrant_angle(mx, my);
      if (!v.px[CW-1] && !v.py[CW-1]) t = a;
      else if (v.px[CW-1] && !v.py[CW-1]) t = (64'd1 << 31) - a;
      else if (v.px[CW-1]) t = (64'd1 << 31) + a;
      else t = (64'd1 << 32) - a;
      t = round_angle(t);
      r.phi = t[AB:0];
    end
    if (r.theta_valid) begin
      ptx = floor_root(s << (2 * (63 - CW)));
      a = quadrant_angle(mz << (63 - CW), ptx);
      t = v.pz[CW-1] ? (64'd1 << 31) - a : a;
      t = round_angle(t);
      r.theta = t[AB-1:0];
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      3: return CW'($urandom_range(0, 255)) - CW'(128);
      4: return CW'($urandom_range(0, 1) ? -1 : 1) << $urandom_range(0, CW-2);
      default: return CW'($urandom());
    endcase
  endfunction

  // Driver: offers queued items with a random gap before each.
  int unsigned src_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.px <= '0;
      in_if.py <= '0;
      in_if.pz <= '0;
      src_gap <= $urandom_range(0, 17);
    end else if (in_if.valid && !in_acc) begin
      // Hold the offered item until it is taken.
    end else if (src_gap != 0) begin
      in_if.valid <= 1'b0;
      src_gap <= src_gap - 1;
    end else if (pending_vecs.size() != 0) begin
      vec_t v;
      v = pending_vecs.pop_front();
      in_if.valid <= 1'b1;
      in_if.px <= v.px;
      in_if.py <= v.py;
      in_if.pz <= v.pz;
      src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Predict on acceptance.
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_polar.push_back(to_polar({in_if.px, in_if.py, in_if.pz}));
      n_sent <= n_sent + 1;
    end
  end

  // Receiver ready with random stalls, plus one long hold-off on request.
  int unsigned snk_gap = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (snk_gap != 0) begin
      out_if.ready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (out_acc)
        snk_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_acc <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      polar_t e;
      if (expected_polar.size() == 0) begin
        $error("result with nothing expected: pt=%0d phi=%0d theta=%0d",
               out_if.pt, out_if.phi, out_if.theta);
        n_errors++;
      end else begin
        e = expected_polar.pop_front();
        if (out_if.pt !== e.pt) begin
          $error("pt expected %0d got %0d", e.pt, out_if.pt); n_errors++;
        end
        if (out_if.phi !== e.phi) begin
          $error("phi expected %0d got %0d", e.phi, out_if.phi); n_errors++;
        end
        if (out_if.phi_valid !== e.phi_valid) begin
          $error("phi_valid expected %0d got %0d", e.phi_valid, out_if.phi_valid);
          n_errors++;
        end
        if (out_if.theta !== e.theta) begin
          $error("theta expected %0d got %0d", e.theta, out_if.theta); n_errors++;
        end
        if (out_if.theta_valid !== e.theta_valid) begin
          $error("theta_valid expected %0d got %0d", e.theta_valid, out_if.theta_valid);
          n_errors++;
        end
      end
      n_checked <= n_checked + 1;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_polar.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_vec(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    pending_vecs.push_back({x, y, z});
  endtask

  task automatic wait_drained();
    while (pending_vecs.size() != 0 || in_if.valid || expected_polar.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [CW-1:0] mx;
    logic [CW-1:0] mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero vector, axes, extremes, wrap near a full turn.
    push_vec('0, '0, '0);
    push_vec('0, '0, 32'd65536);
    push_vec('0, '0, -32'sd65536);
    push_vec(32'd65536, '0, '0);
    push_vec(-32'sd65536, '0, '0);
    push_vec('0, 32'd65536, '0);
    push_vec('0, -32'sd65536, '0);
    push_vec(mx, mx, mx);
    push_vec(mn, mn, mn);
    push_vec(mn, mx, '0);
    push_vec(mx, mn, mn);
    push_vec(mx, -32'sd1, '0);
    push_vec(32'd1, -32'sd1, 32'd1);
    push_vec(-32'sd1, 32'd1, -32'sd1);
    push_vec(mx, 32'd1, '0);
    push_vec(-32'sd1, mn, mx);
    push_vec('0, '0, mn);
    push_vec('0, '0, mx);
    push_vec(32'd3, 32'd4, '0);
    push_vec(-32'sd3, -32'sd4, 32'd5);
    wait_drained();

    // Receiver holds off long enough for the pipeline to fill and stall the input.
    for (int i = 0; i < 300; i++) push_vec(rand_coord(), rand_coord(), rand_coord());
    hold_req = 1'b1;
    wait_drained();

    for (int i = 0; i < N_RANDOM - 300; i++) begin
      push_vec(rand_coord(), rand_coord(), rand_coord());
      if (i % 200 == 199) wait_drained();
    end
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("Sent %0d vectors and checked %0d results, incl. axes, zeros and extremes.",
             n_sent, n_checked);
    $display("Stalls on both sides, including a long receiver hold-off.");
    if (n_errors == 0 && expected_polar.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
